// ===== hw/rtl/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

    localparam int BLOCK_COUNT = 4096;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BLK_W       = 12;
    localparam int KIND_W      = 2;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;

    typedef logic [WORD_BITS-1:0] map_word_t;
    typedef logic [WADDR_W-1:0]   word_addr_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;
    typedef logic [BLK_W-1:0]     blk_t;
    typedef logic [KIND_W-1:0]    req_kind_t;

    localparam req_kind_t REQ_ALLOC  = 2'd0;
    localparam req_kind_t REQ_MARK   = 2'd1;
    localparam req_kind_t REQ_FREE   = 2'd2;
    localparam req_kind_t REQ_UNUSED = 2'd3;

    // Power-on content of a map word: blocks 0 and 1 are reserved, and
    // positions past the last block stay clear.
    function automatic map_word_t reset_word(input word_addr_t addr);
        map_word_t w;
        int        n;
        for (int b = 0; b < WORD_BITS; b++) begin
            n    = int'(addr) * WORD_BITS + b;
            w[b] = (n >= 2) && (n < BLOCK_COUNT);
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                     tuser
// s_        in   [11:0] block_num, [15:12] zero          [1:0] req_type
// m_        out  [11:0] granted_block, [12] status, pad   -
//
// Allocate: accept the request, then one map word per cycle until a free
// block is seen or the last word is read, a rate set by the single read port
// of the map RAM. Mark-used and free: read, then write back. Unused code or
// a block out of range: no write. ST_RESULT then loads the output register.
// Reset: synchronous, active low; per-word valid flops make the map read as
// its formatted state at once, no clearing pass. m_ stalls back up to s_tready.

module bitmap_block_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bba_pkg::S_DATA_W-1:0] s_tdata,   // [11:0] block_num
    input  logic [bba_pkg::KIND_W-1:0]   s_tuser,   // [1:0] req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bba_pkg::M_DATA_W-1:0] m_tdata    // [11:0] granted_block, [12] status
);
    import bba_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_RESULT = 3'd3;

    localparam word_addr_t LAST_WORD = word_addr_t'(MAP_WORDS - 1);

    logic [2:0]     state_reg, state_next;
    req_kind_t      kind_reg, kind_next;
    blk_t           blk_reg, blk_next;
    blk_t           res_grant_reg, res_grant_next;
    logic           res_status_reg, res_status_next;
    logic           m_valid_reg;
    blk_t           m_grant_reg;
    logic           m_status_reg;
    logic           out_load;

    map_word_t      mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    map_word_t      rd_q;
    word_addr_t     rd_addr, rd_addr_q;
    logic           wr_en;
    map_word_t      wr_data;
    map_word_t      word_cur;
    map_word_t      iso;
    bit_idx_t       low_idx;
    map_word_t      named_onehot;

    logic           s_fire;
    req_kind_t      s_kind;
    blk_t           s_blk;
    logic           s_in_range;

    assign s_kind     = s_tuser;
    assign s_blk      = s_tdata[BLK_W-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign s_in_range = 32'(s_blk) < BLOCK_COUNT;

    // map RAM, one read and one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[rd_addr_q] <= wr_data;
        end
        rd_q      <= mem[rd_addr];
        rd_addr_q <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[rd_addr_q] <= 1'b1;
        end
    end

    assign word_cur = valid_reg[rd_addr_q] ? rd_q : reset_word(rd_addr_q);

    // lowest free bit: isolate, then encode the one-hot position
    assign iso = word_cur & (~word_cur + map_word_t'(1));
    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (iso[i]) begin
                low_idx = low_idx | bit_idx_t'(i);
            end
        end
    end

    assign named_onehot = map_word_t'(1) << blk_reg[BIT_W-1:0];

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        blk_next        = blk_reg;
        res_grant_next  = res_grant_reg;
        res_status_next = res_status_reg;
        rd_addr         = rd_addr_q;
        wr_en           = 1'b0;
        wr_data         = word_cur;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = (s_kind == REQ_ALLOC) ? '0 : s_blk[BIT_W +: WADDR_W];
                if (s_fire) begin
                    kind_next       = s_kind;
                    blk_next        = s_blk;
                    res_grant_next  = s_blk;
                    res_status_next = 1'b0;
                    if (s_kind == REQ_ALLOC) begin
                        state_next = ST_SCAN;
                    end else if (s_kind != REQ_UNUSED && s_in_range) begin
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                rd_addr = rd_addr_q + word_addr_t'(1);
                if (|word_cur) begin
                    wr_en           = 1'b1;
                    wr_data         = word_cur & ~iso;
                    res_grant_next  = blk_t'({rd_addr_q, low_idx});
                    res_status_next = 1'b0;
                    state_next      = ST_RESULT;
                end else if (rd_addr_q == LAST_WORD) begin
                    res_grant_next  = '0;
                    res_status_next = 1'b1;
                    state_next      = ST_RESULT;
                end
            end
            ST_MOD: begin
                wr_en      = 1'b1;
                wr_data    = (kind_reg == REQ_MARK) ? (word_cur & ~named_onehot)
                                                    : (word_cur | named_onehot);
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        blk_reg        <= blk_next;
        res_grant_reg  <= res_grant_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_grant_reg  <= res_grant_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - BLK_W - 1){1'b0}}, m_status_reg, m_grant_reg};

    // only an allocate can report an empty map
    a_status_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_status_reg) |-> (kind_reg == REQ_ALLOC))
        else $error("empty-map status on a non-allocate request");

    // an allocate write-back clears exactly one bit that was free
    a_alloc_one_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && wr_en) |-> $onehot(word_cur ^ wr_data))
        else $error("allocate changed other than one free bit");

    // no RAM write while waiting for a request or delivering a result
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_RESULT) |-> !wr_en)
        else $error("map write outside a request");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
